// File: rtl/ssrq_pkg.sv
// Shared types and codes for the sector-sorted request queue.
package ssrq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int SECTOR_BITS_DEF = 48;
  localparam int TAG_BITS_DEF    = 8;

  localparam logic [1:0] FUNC_ADD  = 2'd0;
  localparam logic [1:0] FUNC_DISP = 2'd1;
  localparam logic [1:0] FUNC_REM  = 2'd2;
  localparam logic [1:0] FUNC_QRY  = 2'd3;

  // Command broadcast to every cell.
  typedef struct packed {
    logic cap;      // compare pass: latch le/match against the key
    logic ins;      // shift pass: insert key
    logic del;      // shift pass: close a gap
    logic del_all;  // gap at slot 0 (dispatch)
  } cell_cmd_t;

  // Status one cell hands to its upper neighbor; first also goes to its lower neighbor.
  typedef struct packed {
    logic le;     // stored sector <= key
    logic hit;    // tag matched at or below this cell
    logic first;  // this cell holds the first match
  } cell_stat_t;

endpackage

// File: rtl/sector_sorted_request_queue_unit.sv
// Top level of the sector-sorted request queue: a row of slot cells and a two-pass sequencer.
// Each item takes a compare pass in every cell on the accept edge, then a shift pass
// in which the tag-hit flag ripples up the cell row; the result is registered at the end of
// the shift pass. A new start is taken only while idle (busy low).
// busy is high for the one shift cycle; the next start is taken while the result is shown.
// Reset (rst_n low, synchronous) empties the queue; the result receiver cannot stall.
module sector_sorted_request_queue_unit #(
  parameter int QUEUE_DEPTH = ssrq_pkg::QUEUE_DEPTH_DEF,
  parameter int SECTOR_BITS = ssrq_pkg::SECTOR_BITS_DEF,
  parameter int TAG_BITS    = ssrq_pkg::TAG_BITS_DEF,
  parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             in_func,
  input  logic [SECTOR_BITS-1:0] in_item_sector,
  input  logic [TAG_BITS-1:0]    in_item_tag,
  output logic                   out_strobe,
  output logic                   out_done_res,
  output logic [SECTOR_BITS-1:0] out_sector,
  output logic [TAG_BITS-1:0]    out_tag,
  output logic                   out_prev_valid,
  output logic [TAG_BITS-1:0]    out_prev_tag,
  output logic                   out_next_valid,
  output logic [TAG_BITS-1:0]    out_next_tag,
  output logic [CNT_W-1:0]       out_queue_count
);
  import ssrq_pkg::*;

  localparam logic PH_IDLE = 1'b0;
  localparam logic PH_EXEC = 1'b1;

  logic                   state_r, state_nxt;
  logic [1:0]             func_r;
  logic [SECTOR_BITS-1:0] key_sector_r;
  logic [TAG_BITS-1:0]    key_tag_r;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;

  logic                   strobe_r;
  logic                   done_r;
  logic [SECTOR_BITS-1:0] osec_r;
  logic [TAG_BITS-1:0]    otag_r;
  logic                   pv_r, nv_r;
  logic [TAG_BITS-1:0]    pt_r, nt_r;

  logic                   accept, exec, full, empty, found;
  cell_cmd_t              cmd;
  logic [SECTOR_BITS-1:0] key_sector;
  logic [TAG_BITS-1:0]    key_tag;

  logic [SECTOR_BITS-1:0] sec_a   [QUEUE_DEPTH];
  logic [TAG_BITS-1:0]    tag_a   [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] vld_v;
  cell_stat_t             stat_a  [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] pv_v, nv_v;
  logic [TAG_BITS-1:0]    pt_a    [QUEUE_DEPTH];
  logic [TAG_BITS-1:0]    nt_a    [QUEUE_DEPTH];
  logic                   any_pv, any_nv;
  logic [TAG_BITS-1:0]    or_pt, or_nt;

  assign accept = start && (state_r == PH_IDLE);
  assign exec   = (state_r == PH_EXEC);
  assign busy   = exec;
  assign full   = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign empty  = (cnt_r == '0);
  assign found  = stat_a[QUEUE_DEPTH-1].hit;

  // Compare against the ports on the capture edge, against the held key after.
  assign key_sector = exec ? key_sector_r : in_item_sector;
  assign key_tag    = exec ? key_tag_r : in_item_tag;

  always_comb begin
    cmd.cap     = accept;
    cmd.ins     = exec && (func_r == FUNC_ADD) && !full;
    cmd.del     = exec && ((func_r == FUNC_DISP) || (func_r == FUNC_REM));
    cmd.del_all = exec && (func_r == FUNC_DISP);
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [SECTOR_BITS-1:0] lo_sector, hi_sector;
    logic [TAG_BITS-1:0]    lo_tag, hi_tag;
    logic                   lo_vld, hi_vld, hi_first;
    cell_stat_t             lo_stat;

    if (i == 0) begin : g_lo_end
      assign lo_sector = '0;
      assign lo_tag    = '0;
      assign lo_vld    = 1'b1;
      assign lo_stat   = '{le: 1'b1, hit: 1'b0, first: 1'b0};
    end else begin : g_lo
      assign lo_sector = sec_a[i-1];
      assign lo_tag    = tag_a[i-1];
      assign lo_vld    = vld_v[i-1];
      assign lo_stat   = stat_a[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_hi_end
      assign hi_sector = '0;
      assign hi_tag    = '0;
      assign hi_vld    = 1'b0;
      assign hi_first  = 1'b0;
    end else begin : g_hi
      assign hi_sector = sec_a[i+1];
      assign hi_tag    = tag_a[i+1];
      assign hi_vld    = vld_v[i+1];
      assign hi_first  = stat_a[i+1].first;
    end

    ssrq_cell #(
      .SECTOR_BITS(SECTOR_BITS),
      .TAG_BITS   (TAG_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .key_sector(key_sector),
      .key_tag   (key_tag),
      .lo_sector (lo_sector),
      .lo_tag    (lo_tag),
      .lo_vld    (lo_vld),
      .lo_stat   (lo_stat),
      .hi_sector (hi_sector),
      .hi_tag    (hi_tag),
      .hi_vld    (hi_vld),
      .hi_first  (hi_first),
      .sector    (sec_a[i]),
      .tag       (tag_a[i]),
      .vld       (vld_v[i]),
      .stat      (stat_a[i]),
      .prev_vld_o(pv_v[i]),
      .prev_tag_o(pt_a[i]),
      .next_vld_o(nv_v[i]),
      .next_tag_o(nt_a[i])
    );
  end

  // At most one cell drives a neighbor tag, so OR the row together.
  always_comb begin
    or_pt = '0;
    or_nt = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      or_pt = or_pt | pt_a[i];
      or_nt = or_nt | nt_a[i];
    end
    any_pv = |pv_v;
    any_nv = |nv_v;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      PH_IDLE: if (accept) state_nxt = PH_EXEC;
      PH_EXEC: state_nxt = PH_IDLE;
      default: state_nxt = PH_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (exec) begin
      unique case (func_r)
        FUNC_ADD:  if (!full) cnt_nxt = cnt_r + 1'b1;
        FUNC_DISP: if (!empty) cnt_nxt = cnt_r - 1'b1;
        FUNC_REM:  if (found) cnt_nxt = cnt_r - 1'b1;
        default:   cnt_nxt = cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= PH_IDLE;
      cnt_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      strobe_r <= exec;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r       <= in_func;
      key_sector_r <= in_item_sector;
      key_tag_r    <= in_item_tag;
    end
  end

  // Register the result at the end of the shift pass.
  always_ff @(posedge clk) begin
    if (exec) begin
      osec_r <= '0;
      otag_r <= '0;
      pv_r   <= 1'b0;
      pt_r   <= '0;
      nv_r   <= 1'b0;
      nt_r   <= '0;
      unique case (func_r)
        FUNC_ADD:  done_r <= !full;
        FUNC_DISP: begin
          done_r <= !empty;
          if (!empty) begin
            osec_r <= sec_a[0];
            otag_r <= tag_a[0];
          end
        end
        FUNC_REM:  done_r <= found;
        FUNC_QRY:  begin
          done_r <= found;
          pv_r   <= any_pv;
          pt_r   <= or_pt;
          nv_r   <= any_nv;
          nt_r   <= or_nt;
        end
        default:   done_r <= 1'b0;
      endcase
    end
  end

  assign out_strobe      = strobe_r;
  assign out_done_res    = done_r;
  assign out_sector      = osec_r;
  assign out_tag         = otag_r;
  assign out_prev_valid  = pv_r;
  assign out_prev_tag    = pt_r;
  assign out_next_valid  = nv_r;
  assign out_next_tag    = nt_r;
  assign out_queue_count = cnt_r;

  a_exec_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("shift pass did not follow an accepted item");

  a_strobe_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (out_strobe && !busy))
    else $error("result not strobed after shift pass");

  a_valid_packed: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(vld_v) == int'(cnt_r))
    else $error("slot valid bits disagree with entry count");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count beyond queue depth");

  a_miss_no_neighbors: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_done_res) |-> (!out_prev_valid && !out_next_valid))
    else $error("neighbor reported for a missing tag");

endmodule

// File: rtl/ssrq_cell.sv
// One slot of the sorted queue: holds an entry and shifts with its neighbors.
module ssrq_cell #(
  parameter int SECTOR_BITS = ssrq_pkg::SECTOR_BITS_DEF,
  parameter int TAG_BITS    = ssrq_pkg::TAG_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ssrq_pkg::cell_cmd_t    cmd,
  input  logic [SECTOR_BITS-1:0] key_sector,
  input  logic [TAG_BITS-1:0]    key_tag,
  input  logic [SECTOR_BITS-1:0] lo_sector,
  input  logic [TAG_BITS-1:0]    lo_tag,
  input  logic                   lo_vld,
  input  ssrq_pkg::cell_stat_t   lo_stat,
  input  logic [SECTOR_BITS-1:0] hi_sector,
  input  logic [TAG_BITS-1:0]    hi_tag,
  input  logic                   hi_vld,
  input  logic                   hi_first,
  output logic [SECTOR_BITS-1:0] sector,
  output logic [TAG_BITS-1:0]    tag,
  output logic                   vld,
  output ssrq_pkg::cell_stat_t   stat,
  output logic                   prev_vld_o,
  output logic [TAG_BITS-1:0]    prev_tag_o,
  output logic                   next_vld_o,
  output logic [TAG_BITS-1:0]    next_tag_o
);
  import ssrq_pkg::*;

  logic [SECTOR_BITS-1:0] sector_r;
  logic [TAG_BITS-1:0]    tag_r;
  logic                   vld_r;
  logic                   le_r;
  logic                   match_r;

  always_comb begin
    stat.le    = le_r;
    stat.hit   = lo_stat.hit | match_r;
    stat.first = match_r & ~lo_stat.hit;
  end

  assign sector     = sector_r;
  assign tag        = tag_r;
  assign vld        = vld_r;
  assign prev_vld_o = hi_first;
  assign prev_tag_o = hi_first ? tag_r : '0;
  assign next_vld_o = lo_stat.first & vld_r;
  assign next_tag_o = (lo_stat.first & vld_r) ? tag_r : '0;

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      le_r    <= vld_r & (sector_r <= key_sector);
      match_r <= vld_r & (tag_r == key_tag);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (cmd.ins) begin
      vld_r <= vld_r | lo_vld;
    end else if (cmd.del && (cmd.del_all || stat.hit)) begin
      vld_r <= hi_vld;
    end
  end

  // Payload: take the key at the insert point, the lower entry above it,
  // the upper entry at and above a deleted slot.
  always_ff @(posedge clk) begin
    if (cmd.ins && !le_r) begin
      if (lo_stat.le) begin
        sector_r <= key_sector;
        tag_r    <= key_tag;
      end else begin
        sector_r <= lo_sector;
        tag_r    <= lo_tag;
      end
    end else if (cmd.del && (cmd.del_all || stat.hit)) begin
      sector_r <= hi_sector;
      tag_r    <= hi_tag;
    end
  end

endmodule
